### hw/rtl/ctit_pkg.sv
// ----------------------------------------------------------------------------
// ctit_pkg
// Shared constants and the byte-wise CRC-32 step for the trailer inserter.
// ----------------------------------------------------------------------------
`default_nettype none

package ctit_pkg;

  localparam logic [31:0] CrcInit      = 32'hFFFF_FFFF;
  localparam logic [31:0] CrcPoly      = 32'hEDB8_8320;
  localparam int unsigned TrailerBytes = 4;

  // reflected crc-32, one byte: eight shift/xor steps on a 32-bit word
  function automatic logic [31:0] crc_update_byte(input logic [31:0] crc,
                                                  input logic [7:0]  data);
    logic [31:0] c;
    c = crc ^ {24'd0, data};
    for (int k = 0; k < 8; k++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CrcPoly;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage

`default_nettype wire

### hw/rtl/ctit_if.sv
// ----------------------------------------------------------------------------
// ctit interfaces
// Valid/ready channels for input bytes and for result bytes.
// ----------------------------------------------------------------------------
`default_nettype none

interface ctit_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;

  modport source (output valid, output in_byte, input ready);
  modport sink   (input valid, input in_byte, output ready);
endinterface

interface ctit_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       is_trailer;
  logic       frame_end;

  modport source (output valid, output out_byte, output is_trailer, output frame_end,
                  input ready);
  modport sink   (input valid, input out_byte, input is_trailer, input frame_end,
                  output ready);
endinterface

`default_nettype wire

### hw/rtl/crc32_frame_trailer_inserter.sv
// ----------------------------------------------------------------------------
// crc32_frame_trailer_inserter
// Passes message payload bytes through and replaces the last four bytes of
// each fixed-size message with the inverted reflected CRC-32, low byte first.
// ----------------------------------------------------------------------------
// usage
//   in_i  : one message byte per item; bytes at the four trailer positions of
//           each message are taken but their value is dropped
//   out_o : one item per input item: out_byte, is_trailer, frame_end
//   result: registered; it goes to the output register, or to the skid register while a result waits
//   throughput: one byte per clock while in_i.ready is high; the crc step for one
//           byte is a single combinational pass from the crc register back into it
//   stall: results sit in an output register backed by a one-entry skid
//           register, so the block keeps taking a byte while a result waits;
//           in_i.ready drops only when both are full
//   reset: crc register to all ones, byte position to zero, both result
//           registers empty
//   after the last byte of a message the position wraps to zero and the crc
//   goes back to all ones
// ----------------------------------------------------------------------------
`default_nettype none

module crc32_frame_trailer_inserter #(
  parameter int unsigned MESSAGE_BYTES = 32
) (
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  ctit_in_if.sink     in_i,
  ctit_out_if.source  out_o
);
  import ctit_pkg::*;

  localparam int unsigned PosW       = $clog2(MESSAGE_BYTES);
  localparam int unsigned PayloadLen = MESSAGE_BYTES - TrailerBytes;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       is_trailer;
    logic       frame_end;
  } res_t;

  // message state
  logic [31:0]     crc_q, crc_d;
  logic [PosW-1:0] pos_q, pos_d;

  // result buffer: output register plus skid register
  logic out_valid_q, out_valid_d;
  logic skid_valid_q, skid_valid_d;
  res_t out_q, out_d;
  res_t skid_q, skid_d;

  logic        in_acc;
  logic        out_free;
  logic        is_payload;
  logic        is_last;
  logic [31:0] crc_fin;
  logic [1:0]  trl_idx;
  res_t        res;

  assign in_i.ready = ~skid_valid_q;
  assign in_acc     = in_i.valid & in_i.ready;
  assign out_free   = ~out_valid_q | out_o.ready;

  // result for the byte at the current position
  assign is_payload = (pos_q < PosW'(PayloadLen));
  assign is_last    = (pos_q == PosW'(MESSAGE_BYTES - 1));
  assign crc_fin    = ~crc_q;
  assign trl_idx    = 2'(pos_q - PosW'(PayloadLen));

  always_comb begin
    res.is_trailer = ~is_payload;
    res.frame_end  = is_last;
    res.out_byte   = is_payload ? in_i.in_byte : crc_fin[8*trl_idx +: 8];
  end

  // position advances on every accepted byte, crc on every accepted payload byte
  always_comb begin
    crc_d = crc_q;
    pos_d = pos_q;
    if (in_acc) begin
      if (is_last) begin
        crc_d = CrcInit;
        pos_d = '0;
      end else begin
        pos_d = pos_q + 1'b1;
        if (is_payload) begin
          crc_d = crc_update_byte(crc_q, in_i.in_byte);
        end
      end
    end
  end

  // buffer control: skid drains first, new result goes to whichever slot is free
  always_comb begin
    out_valid_d  = out_valid_q;
    skid_valid_d = skid_valid_q;
    out_d        = out_q;
    skid_d       = skid_q;
    if (out_free) begin
      if (skid_valid_q) begin
        out_d        = skid_q;
        out_valid_d  = 1'b1;
        skid_valid_d = 1'b0;
      end else if (in_acc) begin
        out_d       = res;
        out_valid_d = 1'b1;
      end else begin
        out_valid_d = 1'b0;
      end
    end else if (in_acc) begin
      skid_d       = res;
      skid_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      crc_q        <= CrcInit;
      pos_q        <= '0;
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      crc_q        <= crc_d;
      pos_q        <= pos_d;
      out_valid_q  <= out_valid_d;
      skid_valid_q <= skid_valid_d;
    end
  end

  // payload registers carry no reset
  always_ff @(posedge clk_i) begin
    out_q  <= out_d;
    skid_q <= skid_d;
  end

  assign out_o.valid      = out_valid_q;
  assign out_o.out_byte   = out_q.out_byte;
  assign out_o.is_trailer = out_q.is_trailer;
  assign out_o.frame_end  = out_q.frame_end;

endmodule

`default_nettype wire

### hw/rtl/ctit_checker.sv
// ----------------------------------------------------------------------------
// ctit_checker
// Port-level checks on the trailer inserter, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module ctit_checker (
  input wire logic       clk_i,
  input wire logic       rst_ni,
  input wire logic       in_valid_i,
  input wire logic       in_ready_i,
  input wire logic       out_valid_i,
  input wire logic       out_ready_i,
  input wire logic [7:0] out_byte_i,
  input wire logic       is_trailer_i,
  input wire logic       frame_end_i
);
  import ctit_pkg::*;

  logic       out_acc;
  logic [1:0] trl_run_q;

  assign out_acc = out_valid_i & out_ready_i;

  // trailer bytes delivered in a row since the last payload or frame end
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      trl_run_q <= '0;
    end else if (out_acc) begin
      if (!is_trailer_i || frame_end_i) begin
        trl_run_q <= '0;
      end else if (trl_run_q != 2'(TrailerBytes - 1)) begin
        trl_run_q <= trl_run_q + 1'b1;
      end
    end
  end

  a_end_is_trailer: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> (!frame_end_i || is_trailer_i))
    else $error("frame end on a payload byte");

  a_end_after_three: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && frame_end_i) |-> (trl_run_q == 2'(TrailerBytes - 1)))
    else $error("frame end not preceded by three trailer bytes");

  a_no_fifth_trailer: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && is_trailer_i && trl_run_q == 2'(TrailerBytes - 1)) |-> frame_end_i)
    else $error("fourth trailer byte without frame end");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && !out_ready_i) |=>
      (out_valid_i && $stable(out_byte_i) && $stable(is_trailer_i) && $stable(frame_end_i)))
    else $error("stalled result changed");

  a_in_unused: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_i) |=> out_valid_i)
    else $error("accepted byte produced no result");

endmodule

bind crc32_frame_trailer_inserter ctit_checker u_ctit_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (in_i.valid),
  .in_ready_i   (in_i.ready),
  .out_valid_i  (out_o.valid),
  .out_ready_i  (out_o.ready),
  .out_byte_i   (out_o.out_byte),
  .is_trailer_i (out_o.is_trailer),
  .frame_end_i  (out_o.frame_end)
);

`default_nettype wire
